// ===== rtl/mpk_dec_pkg.sv =====
// Package for the msgpack subset token decoder: tag codes, token kinds,
// parser phases, header length lookup and float32-to-thousandths conversion.
// No dependencies.
package mpk_dec_pkg;

    localparam int DATA_W  = 8;
    localparam int VALUE_W = 33;
    localparam int KIND_W  = 4;
    localparam int ACC_W   = 32;

    localparam logic [7:0] TAG_NIL     = 8'hC0;
    localparam logic [7:0] TAG_FALSE   = 8'hC2;
    localparam logic [7:0] TAG_TRUE    = 8'hC3;
    localparam logic [7:0] TAG_BIN8    = 8'hC4;
    localparam logic [7:0] TAG_BIN16   = 8'hC5;
    localparam logic [7:0] TAG_BIN32   = 8'hC6;
    localparam logic [7:0] TAG_FLOAT32 = 8'hCA;
    localparam logic [7:0] TAG_FLOAT64 = 8'hCB;
    localparam logic [7:0] TAG_UINT8   = 8'hCC;
    localparam logic [7:0] TAG_UINT16  = 8'hCD;
    localparam logic [7:0] TAG_UINT32  = 8'hCE;
    localparam logic [7:0] TAG_INT8    = 8'hD0;
    localparam logic [7:0] TAG_INT16   = 8'hD1;
    localparam logic [7:0] TAG_INT32   = 8'hD2;
    localparam logic [7:0] TAG_STR8    = 8'hD9;
    localparam logic [7:0] TAG_STR16   = 8'hDA;
    localparam logic [7:0] TAG_STR32   = 8'hDB;
    localparam logic [7:0] TAG_ARRAY16 = 8'hDC;
    localparam logic [7:0] TAG_ARRAY32 = 8'hDD;
    localparam logic [7:0] TAG_MAP16   = 8'hDE;
    localparam logic [7:0] TAG_MAP32   = 8'hDF;
    localparam logic [7:0] TAG_POS_MAX = 8'h7F;
    localparam logic [7:0] TAG_NEG_MIN = 8'hE0;

    localparam logic [32:0] FLOAT64_VALUE = 33'd1000;

    typedef enum logic [3:0] {
        TK_MAP       = 4'd0,
        TK_ARRAY     = 4'd1,
        TK_BYTES_HDR = 4'd2,
        TK_PAYLOAD   = 4'd3,
        TK_INT       = 4'd4,
        TK_BOOL      = 4'd5,
        TK_NIL       = 4'd6,
        TK_FLOAT32   = 4'd7,
        TK_FLOAT64   = 4'd8,
        TK_BADTAG    = 4'd9,
        TK_TRUNC     = 4'd10
    } token_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_IGNORE  = 2'd3
    } phase_t;

    function automatic logic [3:0] header_len(input logic [7:0] t);
        logic [3:0] k;
        unique case (t) inside
            TAG_UINT8, TAG_INT8, TAG_STR8, TAG_BIN8:                      k = 4'd1;
            TAG_UINT16, TAG_INT16, TAG_STR16, TAG_BIN16, TAG_ARRAY16,
            TAG_MAP16:                                                    k = 4'd2;
            TAG_FLOAT32, TAG_UINT32, TAG_INT32, TAG_STR32, TAG_BIN32,
            TAG_ARRAY32, TAG_MAP32:                                       k = 4'd4;
            TAG_FLOAT64:                                                  k = 4'd8;
            default:                                                      k = 4'd0;
        endcase
        return k;
    endfunction

    function automatic logic [32:0] float_milli(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [23:0] man;
        logic [33:0] prod;
        logic [40:0] mag;
        logic        big;
        ex   = bits[30:23];
        man  = {1'b1, bits[22:0]};
        prod = {10'd0, man} * 34'd1000;
        big  = 1'b0;
        mag  = '0;
        if (ex >= 8'd158)
            big = 1'b1;
        else if (ex >= 8'd150)
            mag = {7'd0, prod} << (ex - 8'd150);
        else if (ex >= 8'd104)
            mag = {7'd0, prod >> (8'd150 - ex)};
        if (mag > 41'h0_8000_0000)
            big = 1'b1;
        if (bits[31])
            return big ? 33'h1_8000_0000 : (~mag[32:0] + 33'd1);
        return (big || mag[31]) ? 33'h0_7FFF_FFFF : mag[32:0];
    endfunction

endpackage

// ===== rtl/msgpack_subset_token_decoder.sv =====
// Top level of the msgpack subset token decoder: input beat register,
// single-pass tag parser and registered token output.
// Depends on mpk_dec_pkg.
//
// Path: an input beat is held in the input beat register, and its token is then held in the output register.
// Throughput: one input beat per cycle, unless the master side holds back tokens with m_tready low.
// Reset: rst_n clears the parser to await a tag and empties both registers.
module msgpack_subset_token_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [32:0] token_value, [39:33] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // payload_end
);
    import mpk_dec_pkg::*;

    logic                in_valid_reg;
    logic [DATA_W-1:0]   in_byte_reg;
    logic                in_last_reg;

    phase_t              phase_reg, phase_next;
    logic [7:0]          tag_reg, tag_next;
    logic [3:0]          hbl_reg, hbl_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [31:0]         pl_reg, pl_next;

    logic                out_valid_reg;
    token_kind_t         out_kind_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_pend_reg;

    logic                out_free;
    logic                advance;
    logic                emit;
    token_kind_t         kind;
    logic [VALUE_W-1:0]  value;
    logic                pend;

    logic [ACC_W-1:0]    acc_shift;
    logic [3:0]          hbl_dec;
    logic [31:0]         pl_dec;
    logic [3:0]          tag_len;
    logic [31:0]         plen;
    logic                start_pl;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_value_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_pend_reg;

    assign acc_shift = {acc_reg[ACC_W-9:0], in_byte_reg};
    assign hbl_dec   = hbl_reg - 4'd1;
    assign pl_dec    = pl_reg - 32'd1;
    assign tag_len   = header_len(in_byte_reg);

    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        hbl_next   = hbl_reg;
        acc_next   = acc_reg;
        pl_next    = pl_reg;
        emit       = 1'b0;
        kind       = TK_INT;
        value      = '0;
        pend       = 1'b0;
        start_pl   = 1'b0;
        plen       = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                emit = 1'b1;
                if (in_byte_reg <= TAG_POS_MAX)
                begin
                    value = {25'd0, in_byte_reg};
                end
                else if (in_byte_reg >= TAG_NEG_MIN)
                begin
                    value = {{25{1'b1}}, in_byte_reg};
                end
                else if (in_byte_reg[7:4] == 4'h8)
                begin
                    kind  = TK_MAP;
                    value = {29'd0, in_byte_reg[3:0]};
                end
                else if (in_byte_reg[7:4] == 4'h9)
                begin
                    kind  = TK_ARRAY;
                    value = {29'd0, in_byte_reg[3:0]};
                end
                else if (in_byte_reg[7:5] == 3'b101)
                begin
                    start_pl = 1'b1;
                    plen     = {27'd0, in_byte_reg[4:0]};
                end
                else if (in_byte_reg == TAG_NIL)
                begin
                    kind = TK_NIL;
                end
                else if (in_byte_reg == TAG_FALSE)
                begin
                    kind = TK_BOOL;
                end
                else if (in_byte_reg == TAG_TRUE)
                begin
                    kind  = TK_BOOL;
                    value = 33'd1;
                end
                else if (tag_len == 4'd0)
                begin
                    kind       = TK_BADTAG;
                    value      = {25'd0, in_byte_reg};
                    phase_next = PH_IGNORE;
                end
                else if (in_last_reg)
                begin
                    kind = TK_TRUNC;
                end
                else
                begin
                    emit       = 1'b0;
                    tag_next   = in_byte_reg;
                    hbl_next   = tag_len;
                    acc_next   = '0;
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                acc_next = acc_shift;
                hbl_next = hbl_dec;
                if (hbl_dec == 4'd0)
                begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                    case (tag_reg) inside
                        TAG_MAP16, TAG_MAP32:
                        begin
                            kind  = TK_MAP;
                            value = {1'b0, acc_shift};
                        end
                        TAG_ARRAY16, TAG_ARRAY32:
                        begin
                            kind  = TK_ARRAY;
                            value = {1'b0, acc_shift};
                        end
                        TAG_STR8, TAG_BIN8, TAG_STR16, TAG_BIN16, TAG_STR32, TAG_BIN32:
                        begin
                            start_pl = 1'b1;
                            plen     = acc_shift;
                        end
                        TAG_INT8:    value = {{25{acc_shift[7]}}, acc_shift[7:0]};
                        TAG_INT16:   value = {{17{acc_shift[15]}}, acc_shift[15:0]};
                        TAG_INT32:   value = {acc_shift[31], acc_shift};
                        TAG_FLOAT32:
                        begin
                            kind  = TK_FLOAT32;
                            value = float_milli(acc_shift);
                        end
                        TAG_FLOAT64:
                        begin
                            kind  = TK_FLOAT64;
                            value = FLOAT64_VALUE;
                        end
                        default:     value = {1'b0, acc_shift};
                    endcase
                end
                else if (in_last_reg)
                begin
                    emit = 1'b1;
                    kind = TK_TRUNC;
                end
            end
            PH_PAYLOAD:
            begin
                pl_next = pl_dec;
                emit    = 1'b1;
                if (pl_dec == 32'd0)
                begin
                    phase_next = PH_IDLE;
                    kind       = TK_PAYLOAD;
                    value      = {25'd0, in_byte_reg};
                    pend       = 1'b1;
                end
                else if (in_last_reg)
                begin
                    kind = TK_TRUNC;
                end
                else
                begin
                    kind  = TK_PAYLOAD;
                    value = {25'd0, in_byte_reg};
                end
            end
            PH_IGNORE:
            begin
                emit = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (start_pl)
        begin
            kind  = TK_BYTES_HDR;
            value = {1'b0, plen};
            if (plen != 32'd0)
            begin
                if (in_last_reg)
                begin
                    kind  = TK_TRUNC;
                    value = '0;
                end
                else
                begin
                    pl_next    = plen;
                    phase_next = PH_PAYLOAD;
                end
            end
        end

        if (in_last_reg)
        begin
            phase_next = PH_IDLE;
            tag_next   = '0;
            hbl_next   = '0;
            acc_next   = '0;
            pl_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tag_reg   <= '0;
            hbl_reg   <= '0;
            acc_reg   <= '0;
            pl_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            hbl_reg   <= hbl_next;
            acc_reg   <= acc_next;
            pl_reg    <= pl_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg  <= kind;
            out_value_reg <= value;
            out_pend_reg  <= pend;
        end
    end

endmodule

// ===== tb/sv/tb_msgpack_subset_token_decoder.sv =====
// Testbench for msgpack_subset_token_decoder: directed and random msgpack buffers
// checked token by token against a parser model kept in this file.
// Depends on mpk_dec_pkg and the decoder RTL.
module tb_msgpack_subset_token_decoder;
    import mpk_dec_pkg::*;

    localparam logic [7:0] FIXMAP_BASE    = 8'h80;
    localparam logic [7:0] FIXARRAY_BASE  = 8'h90;
    localparam logic [7:0] FIXSTR_BASE    = 8'hA0;
    localparam logic [7:0] TAG_NEVER_USED = 8'hC1;
    localparam int         RANDOM_BYTES   = 1100;
    localparam int         DRAIN_LIMIT    = 20000;
    localparam int         SETTLE_CYCLES  = 8;

    typedef struct packed {
        token_kind_t kind;
        logic [32:0] value;
        logic        last_byte;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    token_t      tokens_due[$];
    token_t      head_token;
    logic [7:0]  frame_bytes[$];
    int          errors;
    int          useful_bytes;
    int          rx_hold;
    bit          quiet;

    phase_t      prs_phase;
    logic [7:0]  prs_tag;
    logic [3:0]  prs_hdr_left;
    logic [31:0] prs_acc;
    logic [31:0] prs_pay_left;

    msgpack_subset_token_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20 * 1000000);
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [3:0] header_bytes_for(input logic [7:0] t);
        case (t)
            TAG_UINT8, TAG_INT8, TAG_STR8, TAG_BIN8:
                return 4'd1;
            TAG_UINT16, TAG_INT16, TAG_STR16, TAG_BIN16, TAG_ARRAY16, TAG_MAP16:
                return 4'd2;
            TAG_FLOAT32, TAG_UINT32, TAG_INT32, TAG_STR32, TAG_BIN32, TAG_ARRAY32,
            TAG_MAP32:
                return 4'd4;
            TAG_FLOAT64:
                return 4'd8;
            default:
                return 4'd0;
        endcase
    endfunction

    function automatic logic [32:0] thousandths(input logic [31:0] bits);
        int          e;
        logic [63:0] man;
        logic [63:0] mag;
        bit          sat;
        e   = int'(bits[30:23]) - 127;
        man = {40'd0, 1'b1, bits[22:0]};
        mag = '0;
        sat = 1'b0;
        if (e >= 23)
        begin
            if (e - 23 >= 8)
                sat = 1'b1;
            else
                mag = (man << (e - 23)) * 64'd1000;
        end
        else if (e >= -23)
            mag = (man * 64'd1000) >> (23 - e);
        if (!sat && mag > 64'h8000_0000)
            sat = 1'b1;
        if (bits[31])
        begin
            if (sat)
                mag = 64'h8000_0000;
            mag = ~mag + 64'd1;
            return mag[32:0];
        end
        if (sat || mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[32:0];
    endfunction

    task automatic push_token(input token_kind_t kind, input logic [32:0] value,
                              input logic last_byte);
        token_t t;
        t.kind      = kind;
        t.value     = value;
        t.last_byte = last_byte;
        tokens_due.push_back(t);
    endtask

    task automatic open_payload(input logic [31:0] len, input logic last);
        if (len != 32'd0)
        begin
            if (last)
            begin
                push_token(TK_TRUNC, 33'd0, 1'b0);
                return;
            end
            prs_pay_left = len;
            prs_phase    = PH_PAYLOAD;
        end
        push_token(TK_BYTES_HDR, {1'b0, len}, 1'b0);
    endtask

    task automatic close_header(input logic last);
        prs_phase = PH_IDLE;
        case (prs_tag)
            TAG_MAP16, TAG_MAP32:
                push_token(TK_MAP, {1'b0, prs_acc}, 1'b0);
            TAG_ARRAY16, TAG_ARRAY32:
                push_token(TK_ARRAY, {1'b0, prs_acc}, 1'b0);
            TAG_STR8, TAG_STR16, TAG_STR32, TAG_BIN8, TAG_BIN16, TAG_BIN32:
                open_payload(prs_acc, last);
            TAG_INT8:
                push_token(TK_INT, {{25{prs_acc[7]}}, prs_acc[7:0]}, 1'b0);
            TAG_INT16:
                push_token(TK_INT, {{17{prs_acc[15]}}, prs_acc[15:0]}, 1'b0);
            TAG_INT32:
                push_token(TK_INT, {prs_acc[31], prs_acc}, 1'b0);
            TAG_FLOAT32:
                push_token(TK_FLOAT32, thousandths(prs_acc), 1'b0);
            TAG_FLOAT64:
                push_token(TK_FLOAT64, FLOAT64_VALUE, 1'b0);
            default:
                push_token(TK_INT, {1'b0, prs_acc}, 1'b0);
        endcase
    endtask

    task automatic advance_parser(input logic [7:0] b, input logic last);
        logic [3:0] k;
        case (prs_phase)
            PH_IDLE:
            begin
                if (b <= TAG_POS_MAX)
                    push_token(TK_INT, {25'd0, b}, 1'b0);
                else if (b >= TAG_NEG_MIN)
                    push_token(TK_INT, {25'h1FFFFFF, b}, 1'b0);
                else if (b[7:4] == FIXMAP_BASE[7:4])
                    push_token(TK_MAP, {29'd0, b[3:0]}, 1'b0);
                else if (b[7:4] == FIXARRAY_BASE[7:4])
                    push_token(TK_ARRAY, {29'd0, b[3:0]}, 1'b0);
                else if (b[7:5] == FIXSTR_BASE[7:5])
                    open_payload({27'd0, b[4:0]}, last);
                else if (b == TAG_NIL)
                    push_token(TK_NIL, 33'd0, 1'b0);
                else if (b == TAG_FALSE)
                    push_token(TK_BOOL, 33'd0, 1'b0);
                else if (b == TAG_TRUE)
                    push_token(TK_BOOL, 33'd1, 1'b0);
                else
                begin
                    k = header_bytes_for(b);
                    if (k == 4'd0)
                    begin
                        prs_phase = PH_IGNORE;
                        push_token(TK_BADTAG, {25'd0, b}, 1'b0);
                    end
                    else if (last)
                        push_token(TK_TRUNC, 33'd0, 1'b0);
                    else
                    begin
                        prs_tag      = b;
                        prs_hdr_left = k;
                        prs_acc      = '0;
                        prs_phase    = PH_HEADER;
                    end
                end
            end
            PH_HEADER:
            begin
                prs_acc      = {prs_acc[23:0], b};
                prs_hdr_left = prs_hdr_left - 4'd1;
                if (prs_hdr_left == 4'd0)
                    close_header(last);
                else if (last)
                    push_token(TK_TRUNC, 33'd0, 1'b0);
            end
            PH_PAYLOAD:
            begin
                prs_pay_left = prs_pay_left - 32'd1;
                if (prs_pay_left == 32'd0)
                begin
                    prs_phase = PH_IDLE;
                    push_token(TK_PAYLOAD, {25'd0, b}, 1'b1);
                end
                else if (last)
                    push_token(TK_TRUNC, 33'd0, 1'b0);
                else
                    push_token(TK_PAYLOAD, {25'd0, b}, 1'b0);
            end
            default:
                ;
        endcase
        if (last)
        begin
            prs_phase    = PH_IDLE;
            prs_tag      = '0;
            prs_hdr_left = '0;
            prs_acc      = '0;
            prs_pay_left = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        errors++;
        if (errors <= 50)
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tokens_due.size() == 0)
                report_mismatch("unexpected token", m_tdata, 40'd0);
            else
            begin
                head_token = tokens_due.pop_front();
                if (m_tuser != head_token.kind)
                    report_mismatch("token_kind", 40'(m_tuser), 40'(head_token.kind));
                if (m_tdata[32:0] != head_token.value)
                    report_mismatch("token_value", 40'(m_tdata[32:0]),
                                    40'(head_token.value));
                if (m_tdata[39:33] != 7'd0)
                    report_mismatch("tdata pad", 40'(m_tdata[39:33]), 40'd0);
                if (m_tlast != head_token.last_byte)
                    report_mismatch("payload_end", 40'(m_tlast), 40'(head_token.last_byte));
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (prs_phase != PH_IGNORE)
            useful_bytes++;
        advance_parser(b, last);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frame_bytes.delete();
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_be(input logic [63:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            frame_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic add_bytes_value(input logic [7:0] tag, input int lw, output bit open_end);
        logic [31:0] len;
        int          i;
        int          k;
        open_end = 1'b0;
        if (lw > 1 && $urandom_range(0, 3) == 0)
        begin
            len = (lw == 2) ? $urandom_range(0, 65535) : $urandom;
            if (len < 32'd8)
                len = len + 32'd8;
            k = $urandom_range(0, 3);
            open_end = 1'b1;
        end
        else
        begin
            if (lw == 1 && $urandom_range(0, 9) == 0)
                len = $urandom_range(0, 255);
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(0, 40);
            else
                len = $urandom_range(0, 6);
            k = len;
        end
        frame_bytes.push_back(tag);
        push_be({32'd0, len}, lw);
        for (i = 0; i < k; i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_value(output bit open_end);
        logic [7:0]  t;
        logic [31:0] fbits;
        int          len;
        int          i;
        open_end = 1'b0;
        case ($urandom_range(0, 21))
            0:  frame_bytes.push_back(8'($urandom_range(0, TAG_POS_MAX)));
            1:  frame_bytes.push_back(8'($urandom_range(TAG_NEG_MIN, 255)));
            2:  frame_bytes.push_back(FIXMAP_BASE | 8'($urandom_range(0, 15)));
            3:  frame_bytes.push_back(FIXARRAY_BASE | 8'($urandom_range(0, 15)));
            4:
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
                frame_bytes.push_back(FIXSTR_BASE | 8'(len));
                for (i = 0; i < len; i++)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            5:  frame_bytes.push_back(TAG_NIL);
            6:  frame_bytes.push_back(TAG_FALSE);
            7:  frame_bytes.push_back(TAG_TRUE);
            8:  begin frame_bytes.push_back(TAG_UINT8);  push_be({32'd0, $urandom}, 1); end
            9:  begin frame_bytes.push_back(TAG_UINT16); push_be({32'd0, $urandom}, 2); end
            10: begin frame_bytes.push_back(TAG_UINT32); push_be({32'd0, $urandom}, 4); end
            11: begin frame_bytes.push_back(TAG_INT8);   push_be({32'd0, $urandom}, 1); end
            12: begin frame_bytes.push_back(TAG_INT16);  push_be({32'd0, $urandom}, 2); end
            13: begin frame_bytes.push_back(TAG_INT32);  push_be({32'd0, $urandom}, 4); end
            14:
            begin
                if ($urandom_range(0, 1) == 0)
                    fbits = $urandom;
                else
                    fbits = {1'($urandom_range(0, 1)), 8'($urandom_range(97, 165)),
                             23'($urandom)};
                frame_bytes.push_back(TAG_FLOAT32);
                push_be({32'd0, fbits}, 4);
            end
            15: begin frame_bytes.push_back(TAG_FLOAT64); push_be({$urandom, $urandom}, 8); end
            16:
            begin
                t = $urandom_range(0, 1) ? TAG_MAP16 : TAG_MAP32;
                frame_bytes.push_back(t);
                push_be({32'd0, $urandom}, (t == TAG_MAP16) ? 2 : 4);
            end
            17:
            begin
                t = $urandom_range(0, 1) ? TAG_ARRAY16 : TAG_ARRAY32;
                frame_bytes.push_back(t);
                push_be({32'd0, $urandom}, (t == TAG_ARRAY16) ? 2 : 4);
            end
            18: add_bytes_value($urandom_range(0, 1) ? TAG_STR8 : TAG_BIN8, 1, open_end);
            19: add_bytes_value($urandom_range(0, 1) ? TAG_STR16 : TAG_BIN16, 2, open_end);
            20: add_bytes_value($urandom_range(0, 1) ? TAG_STR32 : TAG_BIN32, 4, open_end);
            default:
            begin
                do
                    t = 8'($urandom_range(TAG_NEVER_USED, TAG_MAP32));
                while (header_bytes_for(t) != 4'd0 || t == TAG_FALSE || t == TAG_TRUE);
                frame_bytes.push_back(t);
                len = $urandom_range(0, 4);
                for (i = 0; i < len; i++)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                open_end = 1'b1;
            end
        endcase
    endtask

    task automatic build_frame(input int max_values);
        int n;
        int v;
        bit open_end;
        n        = $urandom_range(1, max_values);
        open_end = 1'b0;
        for (v = 0; v < n && !open_end; v++)
            add_value(open_end);
    endtask

    task automatic test_directed();
        frame_bytes = '{TAG_POS_MAX, TAG_NEG_MIN, FIXMAP_BASE | 8'h0F, FIXARRAY_BASE,
                        TAG_NIL, TAG_FALSE, TAG_TRUE, FIXSTR_BASE, FIXSTR_BASE | 8'h01,
                        8'hFF, TAG_INT8, 8'h80, TAG_FLOAT32, 8'hFF, 8'h80, 8'h00, 8'h00,
                        TAG_NEVER_USED, 8'h55};
        send_frame();
        frame_bytes = '{TAG_UINT8};
        send_frame();
        frame_bytes = '{FIXSTR_BASE | 8'h03, 8'h00};
        send_frame();
        frame_bytes = '{TAG_STR8, 8'h02};
        send_frame();
        frame_bytes = '{TAG_FLOAT32, 8'h4F, 8'h00, 8'h00, 8'h00};
        send_frame();
        drain();
    endtask

    task automatic test_output_hold();
        int start;
        quiet   = 1'b1;
        rx_hold = 300;
        start   = useful_bytes;
        while (useful_bytes - start < 60)
        begin
            build_frame(8);
            send_frame();
        end
        quiet = 1'b0;
        drain();
    endtask

    task automatic test_sender_pause();
        int f;
        for (f = 0; f < 6; f++)
        begin
            build_frame(4);
            send_frame();
            drain();
        end
    endtask

    task automatic test_random_buffers();
        int start;
        int r;
        int i;
        int n;
        int keep;
        start = useful_bytes;
        while (useful_bytes - start < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 15) == 0)
                quiet = ~quiet;
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                build_frame(6);
                if (r == 1)
                begin
                    keep = $urandom_range(1, frame_bytes.size());
                    while (frame_bytes.size() > keep)
                        void'(frame_bytes.pop_back());
                end
            end
            send_frame();
        end
        quiet = 1'b0;
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        errors       = 0;
        useful_bytes = 0;
        rx_hold      = 0;
        quiet        = 1'b0;
        prs_phase    = PH_IDLE;
        prs_tag      = '0;
        prs_hdr_left = '0;
        prs_acc      = '0;
        prs_pay_left = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_output_hold();
        test_sender_pause();
        test_random_buffers();

        if (tokens_due.size() != 0)
            report_mismatch("tokens never produced", 40'(tokens_due.size()), 40'd0);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
